// ----- sv/tmas_pkg.sv -----
// Shared types, constants and the decay ROM of the trackball motion smoother.
package tmas_pkg;

  localparam int DECAY_ENTRIES = 256;
  localparam int OUT_BITS      = 16;

  localparam int IDX_W      = $clog2(DECAY_ENTRIES);
  localparam int CNT_W      = (IDX_W > 1) ? $clog2(IDX_W) : 1;
  localparam int DIV_W      = 8 + IDX_W;
  localparam int DECAY_W    = 16;
  localparam int GAIN_W     = 17;
  localparam int DELTA_W    = 9;
  localparam int MUL_W      = (OUT_BITS + 1 > 20) ? OUT_BITS + 1 : 20;
  localparam int ACC_W      = 2 * MUL_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(256);
  localparam logic [MUL_W-1:0]  BOOST_MULT = MUL_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCROLL_MODE      = 3'd0,
    REG_MOUSE_MAX_SPEED  = 3'd1,
    REG_MOUSE_MAX_TIME   = 3'd2,
    REG_MOUSE_SMOOTHING  = 3'd3,
    REG_SCROLL_MAX_SPEED = 3'd4,
    REG_SCROLL_MAX_TIME  = 3'd5,
    REG_SCROLL_SMOOTHING = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  left_count;
    logic [7:0]  right_count;
    logic [7:0]  up_count;
    logic [7:0]  down_count;
    logic        switch_level;
    logic [15:0] interval_ms;
  } poll_t;

  typedef struct packed {
    logic                       x_valid;
    logic signed [OUT_BITS-1:0] x_value;
    logic                       y_valid;
    logic signed [OUT_BITS-1:0] y_value;
    logic                       report_scroll;
    logic                       key_changed;
    logic                       key_pressed;
  } report_t;

  typedef struct packed {
    logic en;
    logic accum;
  } mac_op_t;

  typedef logic [DECAY_ENTRIES-1:0][DECAY_W-1:0] decay_rom_t;

  // shift-subtract divide, used only while building the ROM
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-3i/N) in Q1.15 from a Q28 Taylor sum of exp(+3i/N)
  function automatic decay_rom_t build_decay();
    decay_rom_t  rom;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] e;
    logic        done;
    for (int i = 0; i < DECAY_ENTRIES; i++) begin
      y    = udiv64(64'(3 * i) << 28, 64'(DECAY_ENTRIES));
      term = 64'd1 << 28;
      sum  = term;
      done = 1'b0;
      for (int k = 1; k <= 48; k++) begin
        if (!done) begin
          term = udiv64((term * y) >> 28, 64'(k));
          if (term == 64'd0) begin
            done = 1'b1;
          end else begin
            sum = sum + term;
          end
        end
      end
      e = udiv64((64'd1 << 43) + (sum >> 1), sum);
      if (e > 64'd32768) begin
        e = 64'd32768;
      end
      rom[i] = e[DECAY_W-1:0];
    end
    return rom;
  endfunction

  localparam decay_rom_t DECAY_ROM = build_decay();

endpackage

// ----- sv/tmas_mac.sv -----
// Shared signed multiply-accumulate unit with its result register.
module tmas_mac import tmas_pkg::*; (
  input  logic                    clk,
  input  mac_op_t                 op,
  input  logic signed [MUL_W-1:0] a,
  input  logic signed [MUL_W-1:0] b,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [2*MUL_W-1:0] prod;
  logic signed [ACC_W-1:0]   base;

  assign prod = a * b;
  assign base = op.accum ? acc : '0;

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc <= base + ACC_W'(prod);
    end
  end

endmodule

// ----- sv/trackball_motion_accel_smoother.sv -----
// Top level: trackball poll processor with exponential acceleration and smoothing.
// Acceptance goes straight to the result when neither axis moves; with motion each axis is
// scaled, blended and stored in turn, preceded by a bit-serial index divide and gain multiply
// when the interval is inside the acceleration window, and by a boost multiply in scroll mode.
// One poll at a time, taken the cycle after the previous result loads;
// the shared 20x20 multiply-accumulate serves 3 uses per axis plus gain and boost.
// Synchronous rst restores register defaults, clears smoothed history and switch level.
module trackball_motion_accel_smoother import tmas_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  poll_t                 in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output report_t               out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_GAIN,
    ST_GAIN_WB,
    ST_BOOST,
    ST_BOOST_WB,
    ST_SCALE,
    ST_SCALE_WB,
    ST_NEW,
    ST_OLD,
    ST_STORE,
    ST_FINISH
  } state_t;

  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  state_t state;

  logic       scroll_mode;
  logic [6:0] mouse_max_speed;
  logic [7:0] mouse_max_time;
  logic [9:0] mouse_smoothing;
  logic [6:0] scroll_max_speed;
  logic [7:0] scroll_max_time;
  logic [9:0] scroll_smoothing;

  logic signed [OUT_BITS-1:0] last_x;
  logic signed [OUT_BITS-1:0] last_y;
  logic                       last_switch;

  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;
  logic                      key_changed;
  logic                      key_pressed;
  logic                      axis;
  logic [CNT_W-1:0]          cnt;
  logic [7:0]                rem;
  logic [IDX_W-1:0]          dlo;
  logic [IDX_W-1:0]          quot;
  logic [GAIN_W-1:0]         gain;
  logic signed [MUL_W-1:0]   scaled;

  logic [6:0]                spd;
  logic [6:0]                spd_m1;
  logic [7:0]                mtime;
  logic [9:0]                smf;
  logic signed [10:0]        w_old;
  logic signed [DELTA_W-1:0] dx_in;
  logic signed [DELTA_W-1:0] dy_in;
  logic [DIV_W-1:0]          div_start;
  logic [8:0]                rem_sh;
  logic                      q_bit;
  logic signed [DELTA_W-1:0] delta_sel;
  logic signed [OUT_BITS-1:0] prev_sel;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   q256;
  logic signed [OUT_BITS-1:0] sat_v;
  logic                      in_fire;
  logic                      out_free;

  mac_op_t                 mop;
  logic signed [MUL_W-1:0] ma;
  logic signed [MUL_W-1:0] mb;

  function automatic logic signed [ACC_W-1:0] div256(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] adj;
    adj = v + (v[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
    return adj >>> 8;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign spd    = scroll_mode ? scroll_max_speed : mouse_max_speed;
  assign mtime  = scroll_mode ? scroll_max_time : mouse_max_time;
  assign smf    = scroll_mode ? scroll_smoothing : mouse_smoothing;
  assign spd_m1 = (spd == 7'd0) ? 7'd0 : spd - 7'd1;
  assign w_old  = $signed(11'd256) - $signed({1'b0, smf});

  assign dx_in = $signed({1'b0, in_data.right_count}) - $signed({1'b0, in_data.left_count});
  assign dy_in = $signed({1'b0, in_data.down_count}) - $signed({1'b0, in_data.up_count});
  assign div_start = DIV_W'(in_data.interval_ms[7:0]) * DIV_W'(DECAY_ENTRIES);

  assign rem_sh = {rem, dlo[IDX_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, mtime});

  assign delta_sel = axis ? dy : dx;
  assign prev_sel  = axis ? last_y : last_x;

  assign q256 = div256(acc);

  always_comb begin
    if (q256 > SAT_HI) begin
      sat_v = SAT_HI[OUT_BITS-1:0];
    end else if (q256 < SAT_LO) begin
      sat_v = SAT_LO[OUT_BITS-1:0];
    end else begin
      sat_v = q256[OUT_BITS-1:0];
    end
  end

  always_comb begin
    mop = '0;
    ma  = '0;
    mb  = '0;
    case (state)
      ST_GAIN: begin
        mop.en = 1'b1;
        ma     = $signed(MUL_W'(spd_m1));
        mb     = $signed(MUL_W'(DECAY_ROM[quot]));
      end
      ST_BOOST: begin
        mop.en = 1'b1;
        ma     = $signed(MUL_W'(gain));
        mb     = $signed(BOOST_MULT);
      end
      ST_SCALE: begin
        mop.en = 1'b1;
        ma     = MUL_W'(delta_sel);
        mb     = $signed(MUL_W'(gain));
      end
      ST_NEW: begin
        mop.en = 1'b1;
        ma     = scaled;
        mb     = $signed(MUL_W'(smf));
      end
      ST_OLD: begin
        mop.en    = 1'b1;
        mop.accum = 1'b1;
        ma        = MUL_W'(w_old);
        mb        = MUL_W'(prev_sel);
      end
      default: begin
        mop = '0;
      end
    endcase
  end

  tmas_mac u_mac (
    .clk (clk),
    .op  (mop),
    .a   (ma),
    .b   (mb),
    .acc (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      last_x           <= '0;
      last_y           <= '0;
      last_switch      <= 1'b0;
      scroll_mode      <= 1'b0;
      mouse_max_speed  <= 7'd25;
      mouse_max_time   <= 8'd5;
      mouse_smoothing  <= 10'd333;
      scroll_max_speed <= 7'd1;
      scroll_max_time  <= 8'd1;
      scroll_smoothing <= 10'd128;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_SCROLL_MODE:      scroll_mode      <= cfg_data[0];
          REG_MOUSE_MAX_SPEED:  mouse_max_speed  <= cfg_data[6:0];
          REG_MOUSE_MAX_TIME:   mouse_max_time   <= cfg_data[7:0];
          REG_MOUSE_SMOOTHING:  mouse_smoothing  <= cfg_data;
          REG_SCROLL_MAX_SPEED: scroll_max_speed <= cfg_data[6:0];
          REG_SCROLL_MAX_TIME:  scroll_max_time  <= cfg_data[7:0];
          REG_SCROLL_SMOOTHING: scroll_smoothing <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            dx          <= dx_in;
            dy          <= dy_in;
            key_changed <= (in_data.switch_level != last_switch);
            key_pressed <= in_data.switch_level;
            last_switch <= in_data.switch_level;
            axis        <= 1'b0;
            rem         <= div_start[DIV_W-1:IDX_W];
            dlo         <= div_start[IDX_W-1:0];
            cnt         <= CNT_W'(IDX_W - 1);
            gain        <= GAIN_ONE;
            if (dx_in == '0 && dy_in == '0) begin
              state <= ST_FINISH;
            end else if (in_data.interval_ms < {8'd0, mtime}) begin
              state <= ST_DIV;
            end else if (scroll_mode) begin
              state <= ST_BOOST;
            end else begin
              state <= ST_SCALE;
            end
          end
        end
        ST_DIV: begin
          rem  <= q_bit ? 8'(rem_sh - {1'b0, mtime}) : rem_sh[7:0];
          dlo  <= dlo << 1;
          quot <= {quot[IDX_W-2:0], q_bit};
          cnt  <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= ST_GAIN;
          end
        end
        ST_GAIN: begin
          state <= ST_GAIN_WB;
        end
        ST_GAIN_WB: begin
          gain  <= GAIN_ONE + acc[7 +: GAIN_W];
          state <= scroll_mode ? ST_BOOST : ST_SCALE;
        end
        ST_BOOST: begin
          state <= ST_BOOST_WB;
        end
        ST_BOOST_WB: begin
          gain  <= acc[1 +: GAIN_W];
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          state <= ST_SCALE_WB;
        end
        ST_SCALE_WB: begin
          scaled <= q256[MUL_W-1:0];
          state  <= ST_NEW;
        end
        ST_NEW: begin
          state <= ST_OLD;
        end
        ST_OLD: begin
          state <= ST_STORE;
        end
        ST_STORE: begin
          if (!axis) begin
            last_x <= sat_v;
            axis   <= 1'b1;
            state  <= ST_SCALE;
          end else begin
            last_y <= sat_v;
            state  <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid              <= 1'b1;
            out_data.x_valid       <= (dx != '0);
            out_data.x_value       <= (dx != '0) ? last_x : '0;
            out_data.y_valid       <= (dy != '0);
            out_data.y_value       <= (dy != '0) ? last_y : '0;
            out_data.report_scroll <= scroll_mode;
            out_data.key_changed   <= key_changed;
            out_data.key_pressed   <= key_pressed;
            state                  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/tmas_chk.sv -----
// Port-level checker for the trackball motion smoother, bound to the top level.
module tmas_chk import tmas_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_stall,
  input logic    out_valid,
  input logic    out_stall,
  input report_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("poll taken while previous transaction in progress");

  a_x_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.x_valid |-> out_data.x_value == '0)
    else $error("x value nonzero without x_valid");

  a_y_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.y_valid |-> out_data.y_value == '0)
    else $error("y value nonzero without y_valid");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a transaction in progress");

endmodule

bind trackball_motion_accel_smoother tmas_chk u_tmas_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- sim/tb_trackball_motion_accel_smoother.sv -----
// Self-checking testbench for the trackball motion acceleration smoother.
module tb_trackball_motion_accel_smoother;
  import tmas_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE       = 40;
  localparam int LIMIT        = 2_000_000;
  localparam int RANDOM_POLLS = 1300;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    poll_t   poll;
    logic    typed;
    report_t rep;
  } step_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] mode;
    logic [CFG_DATA_W-1:0] m_speed;
    logic [CFG_DATA_W-1:0] m_time;
    logic [CFG_DATA_W-1:0] m_smooth;
    logic [CFG_DATA_W-1:0] s_speed;
    logic [CFG_DATA_W-1:0] s_time;
    logic [CFG_DATA_W-1:0] s_smooth;
  } setting_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  poll_t                 in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  report_t               out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // shadow registers and history
  logic                  scroll_on;
  logic [6:0]            m_speed, s_speed;
  logic [7:0]            m_time, s_time;
  logic [9:0]            m_smooth, s_smooth;
  longint                hist_x, hist_y;
  logic                  last_sw;
  logic [15:0]           decay_lut [DECAY_ENTRIES];

  report_t               pending_reports [$];
  report_t               want;
  int                    mismatches = 0;
  int                    polls_sent = 0;
  int                    cycles     = 0;
  int                    stall_left = 0;
  bit                    calm       = 1'b0;
  logic                  sw_level   = 1'b0;

  // left, right, up, down, switch, interval | typed | expected report
  step_t dir_steps [12] = '{
    '{{8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 16'd0}, 1'b1,
      {1'b0, 16'sd0, 1'b0, 16'sd0, 3'b000}},
    '{{8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 16'd65535}, 1'b1,
      {1'b0, 16'sd0, 1'b0, 16'sd0, 3'b011}},
    '{{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 16'd0}, 1'b1,
      {1'b0, 16'sd0, 1'b0, 16'sd0, 3'b001}},
    '{{8'd0, 8'd1, 8'd0, 8'd0, 1'b0, 16'd1000}, 1'b1,
      {1'b1, 16'sd1, 1'b0, 16'sd0, 3'b010}},
    '{{8'd0, 8'd255, 8'd0, 8'd0, 1'b0, 16'd0}, 1'b0, '0},
    '{{8'd255, 8'd0, 8'd0, 8'd0, 1'b1, 16'd4}, 1'b0, '0},
    '{{8'd0, 8'd0, 8'd255, 8'd0, 1'b1, 16'd5}, 1'b0, '0},
    '{{8'd255, 8'd0, 8'd0, 8'd255, 1'b0, 16'd2}, 1'b0, '0},
    '{{8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 16'd7}, 1'b1,
      {1'b0, 16'sd0, 1'b0, 16'sd0, 3'b000}},
    '{{8'd128, 8'd127, 8'd0, 8'd1, 1'b1, 16'h8000}, 1'b0, '0},
    '{{8'd1, 8'd0, 8'd128, 8'd0, 1'b0, 16'h7fff}, 1'b0, '0},
    '{{8'd0, 8'd0, 8'd1, 8'd1, 1'b1, 16'd3}, 1'b1,
      {1'b0, 16'sd0, 1'b0, 16'sd0, 3'b011}}
  };

  // corner settings: mode, pointer speed/time/smoothing, scroll speed/time/smoothing
  setting_t corner_settings [6] = '{
    '{10'd0, 10'd0, 10'd255, 10'd256, 10'd1, 10'd1, 10'd128},
    '{10'h3fe, 10'd64, 10'd0, 10'd1023, 10'd64, 10'd255, 10'd1023},
    '{10'd0, 10'd127, 10'd1, 10'd0, 10'd64, 10'd255, 10'd1023},
    '{10'd1, 10'd25, 10'd5, 10'd333, 10'd64, 10'd255, 10'd1023},
    '{10'd1, 10'd25, 10'd5, 10'd333, 10'd0, 10'd0, 10'd0},
    '{10'h3ff, 10'h3c1, 10'd9, 10'd511, 10'h3ff, 10'd1, 10'd700}
  };

  trackball_motion_accel_smoother i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(21, 100);
  endfunction

  function automatic longint blend_axis(longint delta, longint gain, longint weight,
                                        longint prev);
    longint scaled, mixed, top;
    top    = (longint'(1) <<< (OUT_BITS - 1)) - 1;
    scaled = (delta * gain) / 256;
    mixed  = (weight * scaled + (256 - weight) * prev) / 256;
    if (mixed > top) begin
      mixed = top;
    end else if (mixed < -top - 1) begin
      mixed = -top - 1;
    end
    return mixed;
  endfunction

  function automatic report_t predict_report(poll_t p);
    report_t r;
    longint  dx, dy, spd, win, weight, gain, idx;
    r  = '0;
    dx = longint'(p.right_count) - longint'(p.left_count);
    dy = longint'(p.down_count) - longint'(p.up_count);
    if (dx != 0 || dy != 0) begin
      spd    = longint'(scroll_on ? s_speed : m_speed);
      win    = longint'(scroll_on ? s_time : m_time);
      weight = longint'(scroll_on ? s_smooth : m_smooth);
      if (spd == 0) spd = 1;
      gain = 256;
      if (longint'(p.interval_ms) < win) begin
        idx  = (longint'(p.interval_ms) * longint'(DECAY_ENTRIES)) / win;
        gain = 256 + (((spd - 1) * longint'(decay_lut[idx])) >>> 7);
      end
      if (scroll_on) gain = (gain * 5) >>> 1;
      hist_x = blend_axis(dx, gain, weight, hist_x);
      hist_y = blend_axis(dy, gain, weight, hist_y);
      if (dx != 0) r.x_value = hist_x[OUT_BITS-1:0];
      if (dy != 0) r.y_value = hist_y[OUT_BITS-1:0];
    end
    r.x_valid       = (dx != 0);
    r.y_valid       = (dy != 0);
    r.report_scroll = scroll_on;
    r.key_changed   = (p.switch_level != last_sw);
    r.key_pressed   = p.switch_level;
    last_sw         = p.switch_level;
    return r;
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SCROLL_MODE:      scroll_on = d[0];
      REG_MOUSE_MAX_SPEED:  m_speed   = d[6:0];
      REG_MOUSE_MAX_TIME:   m_time    = d[7:0];
      REG_MOUSE_SMOOTHING:  m_smooth  = d[9:0];
      REG_SCROLL_MAX_SPEED: s_speed   = d[6:0];
      REG_SCROLL_MAX_TIME:  s_time    = d[7:0];
      REG_SCROLL_SMOOTHING: s_smooth  = d[9:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input setting_t s, input logic [6:0] sel, input bit spare);
    if (sel[0]) cfg_write(REG_SCROLL_MODE, s.mode);
    if (sel[1]) cfg_write(REG_MOUSE_MAX_SPEED, s.m_speed);
    if (sel[2]) cfg_write(REG_MOUSE_MAX_TIME, s.m_time);
    if (sel[3]) cfg_write(REG_MOUSE_SMOOTHING, s.m_smooth);
    if (sel[4]) cfg_write(REG_SCROLL_MAX_SPEED, s.s_speed);
    if (sel[5]) cfg_write(REG_SCROLL_MAX_TIME, s.s_time);
    if (sel[6]) cfg_write(REG_SCROLL_SMOOTHING, s.s_smooth);
    if (spare) cfg_write(REG_SPARE, CFG_DATA_W'($urandom_range(0, 1023)));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_poll(input poll_t p, input bit use_typed, input report_t typed);
    int      gap;
    report_t pred;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_report(p);
    pending_reports.push_back(use_typed ? typed : pred);
    polls_sent++;
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_polls(input int n);
    poll_t p;
    int    kind, r;
    for (int i = 0; i < n; i++) begin
      p.left_count  = 8'($urandom_range(0, 255));
      p.right_count = 8'($urandom_range(0, 255));
      p.up_count    = 8'($urandom_range(0, 255));
      p.down_count  = 8'($urandom_range(0, 255));
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        p.right_count = p.left_count;
        p.down_count  = p.up_count;
      end else if (kind < 55) begin
        p.left_count  = 8'($urandom_range(0, 4));
        p.right_count = 8'($urandom_range(0, 4));
        p.up_count    = 8'($urandom_range(0, 4));
        p.down_count  = 8'($urandom_range(0, 4));
      end else if (kind < 65) begin
        p.right_count = p.left_count;
      end else if (kind < 75) begin
        p.down_count = p.up_count;
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
        p.interval_ms = 16'($urandom_range(0, 260));
      end else if (r < 75) begin
        p.interval_ms = 16'($urandom_range(0, 15));
      end else if (r < 90) begin
        p.interval_ms = 16'($urandom_range(0, 65535));
      end else begin
        p.interval_ms = 16'($urandom_range(256, 4000));
      end
      if ($urandom_range(0, 4) == 0) sw_level = ~sw_level;
      p.switch_level = sw_level;
      send_poll(p, 1'b0, '0);
    end
    drain_reports();
  endtask

  // expected vs. actual on every report taken from the output
  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t unexpected report: expected none, actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("x_valid", longint'(want.x_valid), longint'(out_data.x_valid));
        check_field("x_value", longint'(want.x_value), longint'(out_data.x_value));
        check_field("y_valid", longint'(want.y_valid), longint'(out_data.y_valid));
        check_field("y_value", longint'(want.y_value), longint'(out_data.y_value));
        check_field("report_scroll", longint'(want.report_scroll),
                    longint'(out_data.report_scroll));
        check_field("key_changed", longint'(want.key_changed),
                    longint'(out_data.key_changed));
        check_field("key_pressed", longint'(want.key_pressed),
                    longint'(out_data.key_pressed));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!calm && $urandom_range(0, 99) < 25) stall_left <= idle_len();
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("%0t timeout with %0d reports outstanding", $time, pending_reports.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    longint unsigned y_q, term, sum, e;
    setting_t        s;

    // exp(-3i/N) in Q1.15 via reciprocal of a Q28 series for exp(+3i/N)
    for (int i = 0; i < DECAY_ENTRIES; i++) begin
      y_q  = (longint'(3 * i) << 28) / longint'(DECAY_ENTRIES);
      term = 64'd1 << 28;
      sum  = term;
      for (int k = 1; k <= 48; k++) begin
        term = ((term * y_q) >> 28) / longint'(k);
        if (term == 0) break;
        sum += term;
      end
      e = ((64'd1 << 43) + (sum >> 1)) / sum;
      if (e > 32768) e = 32768;
      decay_lut[i] = 16'(e);
    end

    scroll_on = 1'b0;
    m_speed   = 7'd25;
    m_time    = 8'd5;
    m_smooth  = 10'd333;
    s_speed   = 7'd1;
    s_time    = 8'd1;
    s_smooth  = 10'd128;
    hist_x    = 0;
    hist_y    = 0;
    last_sw   = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_steps[i]) begin
      send_poll(dir_steps[i].poll, dir_steps[i].typed, dir_steps[i].rep);
    end
    drain_reports();

    foreach (corner_settings[i]) begin
      apply_setting(corner_settings[i], 7'h7f, 1'b0);
      calm = (i % 3 == 0);
      run_polls($urandom_range(20, 40));
    end

    while (polls_sent < RANDOM_POLLS) begin
      s.mode     = CFG_DATA_W'($urandom_range(0, 1023));
      s.m_speed  = CFG_DATA_W'($urandom_range(0, 1023));
      s.m_time   = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                           : $urandom_range(0, 40));
      s.m_smooth = CFG_DATA_W'($urandom_range(0, 1023));
      s.s_speed  = CFG_DATA_W'($urandom_range(0, 1023));
      s.s_time   = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                           : $urandom_range(0, 40));
      s.s_smooth = CFG_DATA_W'($urandom_range(0, 1023));
      apply_setting(s, 7'($urandom_range(0, 127)), $urandom_range(0, 9) == 0);
      calm = ($urandom_range(0, 3) == 0);
      run_polls($urandom_range(40, 120));
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/tmas_pkg.sv
sv/tmas_mac.sv
sv/trackball_motion_accel_smoother.sv
sv/tmas_chk.sv
sim/tb_trackball_motion_accel_smoother.sv
